### hdl/spi_crc6_frame_master_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the CRC-6 serial frame master
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SPI_CRC6_FRAME_MASTER_TOP_MACROS_SVH
`define SPI_CRC6_FRAME_MASTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCFM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/scfm_pkg.sv
// ----------------------------------------------------------------------------
// scfm_pkg
// Types, constants and CRC helpers shared by the frame master modules.
// ----------------------------------------------------------------------------
package scfm_pkg;

	localparam int FRAME_BITS  = 32;
	localparam int BIT_COUNT_W = 6;

	localparam logic [BIT_COUNT_W-1:0] TX_LAST = BIT_COUNT_W'(FRAME_BITS - 1);
	localparam logic [BIT_COUNT_W-1:0] RX_LAST = BIT_COUNT_W'(2 * FRAME_BITS - 1);

	localparam logic [7:0]  CRC_POLY       = 8'h6C; // 0x5B shifted left by two, low byte
	localparam logic [7:0]  CRC_INIT       = 8'hFC; // 0x3F shifted left by two
	localparam logic [15:0] READ_DUMMY     = 16'h000F;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	typedef enum logic [1:0] {
		KIND_NOP,
		KIND_TICK,
		KIND_WRITE,
		KIND_READ
	} scfm_kind_t;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		scfm_kind_t  kind;
		logic [31:0] frame;
		logic        sdo;
	} scfm_req_t;

	typedef struct packed {
		logic        cs_active;
		logic        sdi;
		logic        frame_end;
		logic        read_valid;
		logic [15:0] read_data;
		logic        rejected;
	} scfm_res_t;

	// Bitwise CRC over the 24 upper frame bits, byte by byte, MSB first.
	// Only evaluated on constants to build the column table and the init term below.
	function automatic logic [5:0] crc_raw(logic [23:0] d, logic [7:0] init);
		logic [7:0] crc;
		crc = init;
		for (int b = 2; b >= 0; b--) begin
			crc ^= d[b*8 +: 8];
			for (int k = 0; k < 8; k++) begin
				if (crc[7]) begin
					crc = {crc[6:0], 1'b0} ^ CRC_POLY;
				end else begin
					crc = {crc[6:0], 1'b0};
				end
			end
		end
		return crc[7:2];
	endfunction

	// The CRC is linear over GF(2): each data bit contributes a fixed column.
	function automatic logic [23:0][5:0] crc_columns();
		logic [23:0][5:0] cols;
		for (int i = 0; i < 24; i++) begin
			cols[i] = crc_raw(24'(1) << i, 8'h00);
		end
		return cols;
	endfunction

	localparam logic [23:0][5:0] CRC_COLS     = crc_columns();
	localparam logic [5:0]       CRC_INIT_CON = crc_raw(24'h000000, CRC_INIT);

endpackage

### hdl/spi_crc6_frame_master_top.sv
// A request accepted into the queue has its result registered by the serial engine once it is popped.
// Throughput: one request per cycle, sustained while out_stall stays low.
// A two-entry queue lets input requests keep flowing while a result waits to be taken.
// Reset (arst_n low, asynchronous) empties the queue and output and leaves the master idle.
// ----------------------------------------------------------------------------
// spi_crc6_frame_master_top
// Serial frame master for a 32-bit register protocol with CRC-6 framing.
// ----------------------------------------------------------------------------
module spi_crc6_frame_master_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  address,
	input  logic [15:0] write_data,
	input  logic        sdo,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        cs_active,
	output logic        sdi,
	output logic        frame_end,
	output logic        read_valid,
	output logic [15:0] read_data,
	output logic        rejected
);
	import scfm_pkg::*;

	scfm_req_t front_req;
	scfm_req_t head;
	scfm_res_t res;
	logic      full;
	logic      not_empty;
	logic      pop;

	assign in_stall = full;

	scfm_front u_front (
		.mode       (mode),
		.address    (address),
		.write_data (write_data),
		.sdo        (sdo),
		.req        (front_req)
	);

	scfm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !full),
		.push_req  (front_req),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	scfm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.res         (res)
	);

	assign cs_active  = res.cs_active;
	assign sdi        = res.sdi;
	assign frame_end  = res.frame_end;
	assign read_valid = res.read_valid;
	assign read_data  = res.read_data;
	assign rejected   = res.rejected;

endmodule

### hdl/scfm_front.sv
// ----------------------------------------------------------------------------
// scfm_front
// Classifies each incoming request and builds the outgoing frame with CRC.
// ----------------------------------------------------------------------------
module scfm_front (
	input  logic               [1:0]  mode,
	input  logic               [7:0]  address,
	input  logic               [15:0] write_data,
	input  logic                      sdo,
	output scfm_pkg::scfm_req_t       req
);
	import scfm_pkg::*;

	logic [15:0] data;
	logic [23:0] upper;
	logic [5:0]  crc;

	assign data  = (mode == MODE_READ) ? READ_DUMMY : write_data;
	assign upper = {address, data};

	// Every data bit adds its own column, so the terms are independent.
	always_comb begin
		crc = CRC_INIT_CON;
		for (int i = 0; i < 24; i++) begin
			if (upper[i]) begin
				crc ^= CRC_COLS[i];
			end
		end
	end

	always_comb begin
		unique case (mode)
			MODE_TICK:  req.kind = KIND_TICK;
			MODE_WRITE: req.kind = KIND_WRITE;
			MODE_READ:  req.kind = KIND_READ;
			default:    req.kind = KIND_NOP;
		endcase
		req.frame = {upper, 2'b00, crc};
		req.sdo   = sdo;
	end

endmodule

### hdl/scfm_queue.sv
// ----------------------------------------------------------------------------
// scfm_queue
// Two-entry request queue between the front and the serial engine.
// ----------------------------------------------------------------------------
module scfm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  scfm_pkg::scfm_req_t push_req,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output scfm_pkg::scfm_req_t head
);
	import scfm_pkg::*;

	scfm_req_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### hdl/scfm_back.sv
// ----------------------------------------------------------------------------
// scfm_back
// Serial engine: runs the frame shifters and registers one result per request.
// ----------------------------------------------------------------------------
module scfm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  scfm_pkg::scfm_req_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output scfm_pkg::scfm_res_t res
);
	import scfm_pkg::*;

	logic [31:0]            tx_shift_q, tx_shift_n;
	logic [31:0]            rx_shift_q, rx_shift_n;
	logic [BIT_COUNT_W-1:0] bit_count_q, bit_count_n;
	logic                   busy_q, busy_n;
	logic                   is_read_q, is_read_n;
	logic                   out_valid_q;
	scfm_res_t              res_q, res_n;

	assign pop       = q_not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		tx_shift_n  = tx_shift_q;
		rx_shift_n  = rx_shift_q;
		bit_count_n = bit_count_q;
		busy_n      = busy_q;
		is_read_n   = is_read_q;
		res_n       = '0;
		// The head entry only holds a request while the queue is not empty.
		if (q_not_empty) begin
			unique case (head.kind)
				KIND_WRITE, KIND_READ: begin
					if (busy_q) begin
						res_n.rejected = 1'b1;
					end else begin
						tx_shift_n  = head.frame;
						rx_shift_n  = '0;
						bit_count_n = '0;
						busy_n      = 1'b1;
						is_read_n   = (head.kind == KIND_READ);
					end
				end
				KIND_TICK: begin
					if (busy_q) begin
						res_n.cs_active = 1'b1;
						// The upper half of the count is the receive frame of a read.
						if (!bit_count_q[BIT_COUNT_W-1]) begin
							res_n.sdi  = tx_shift_q[31];
							tx_shift_n = {tx_shift_q[30:0], 1'b0};
							if (bit_count_q == TX_LAST) begin
								res_n.frame_end = 1'b1;
								if (!is_read_q) begin
									busy_n = 1'b0;
								end
							end
						end else begin
							rx_shift_n = {rx_shift_q[30:0], head.sdo};
							if (bit_count_q == RX_LAST) begin
								res_n.frame_end  = 1'b1;
								res_n.read_valid = 1'b1;
								res_n.read_data  = rx_shift_n[23:8];
								busy_n           = 1'b0;
							end
						end
						bit_count_n = busy_n ? BIT_COUNT_W'(bit_count_q + 1'b1) : '0;
					end
				end
				KIND_NOP: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_shift_q  <= '0;
			rx_shift_q  <= '0;
			bit_count_q <= '0;
			busy_q      <= 1'b0;
			is_read_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				tx_shift_q  <= tx_shift_n;
				rx_shift_q  <= rx_shift_n;
				bit_count_q <= bit_count_n;
				busy_q      <= busy_n;
				is_read_q   <= is_read_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

endmodule

### hdl/scfm_checker.sv
// ----------------------------------------------------------------------------
// scfm_checker
// Port-level checks on the result channel of the frame master.
// ----------------------------------------------------------------------------
`include "spi_crc6_frame_master_top_macros.svh"

module scfm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        cs_active,
	input logic        sdi,
	input logic        frame_end,
	input logic        read_valid,
	input logic [15:0] read_data,
	input logic        rejected
);

	// A completed read always closes a frame that was being clocked.
	`SCFM_ASSERT_IMPLY(a_read_ends_frame, clk, arst_n, out_valid && read_valid, frame_end && cs_active && !sdi && !rejected, "read result without frame end")

	// A refused start clocks nothing.
	`SCFM_ASSERT_IMPLY(a_reject_quiet, clk, arst_n, out_valid && rejected, !cs_active && !frame_end && !read_valid, "rejected request clocked a bit")

	// Without chip select no line activity and no read data are reported.
	`SCFM_ASSERT_IMPLY(a_idle_zero, clk, arst_n, out_valid && !cs_active, !sdi && !frame_end && !read_valid && (read_data == 16'h0000), "activity reported while idle")

	// A stalled result stays in place.
	`SCFM_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(read_data) && $stable(frame_end), "stalled result changed")

endmodule

bind spi_crc6_frame_master_top scfm_checker u_scfm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.cs_active  (cs_active),
	.sdi        (sdi),
	.frame_end  (frame_end),
	.read_valid (read_valid),
	.read_data  (read_data),
	.rejected   (rejected)
);

### tb/sv/spi_crc6_frame_master_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_crc6_frame_master_checker
// Watches both channels of the serial frame master and keeps its own model of
// the frame shifter. Each request produces one predicted tick result, which is
// compared field by field with the result the block delivers.
// ----------------------------------------------------------------------------
module spi_crc6_frame_master_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  address,
	input  logic [15:0] write_data,
	input  logic        sdo,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        cs_active,
	input  logic        sdi,
	input  logic        frame_end,
	input  logic        read_valid,
	input  logic [15:0] read_data,
	input  logic        rejected,
	output int          mismatches,
	output int          pending
);
	import scfm_pkg::*;

	localparam logic [5:0] CRC6_SEED = 6'h3F;
	localparam logic [5:0] CRC6_TAPS = 6'h1B; // 0x5B without its x^6 term
	localparam logic [6:0] TX_TICKS  = 7'(FRAME_BITS);
	localparam logic [6:0] ALL_TICKS = 7'(2 * FRAME_BITS);

	logic [31:0] tx_word;
	logic [31:0] rx_word;
	logic [6:0]  tick_count;
	logic        in_transfer;
	logic        read_txn;

	scfm_res_t   tick_results_q[$];
	scfm_res_t   predicted;
	scfm_res_t   expected;
	int          mismatch_total;
	int          results_seen;

	task automatic report_mismatch(input string what);
		$display("[%0t] result %0d: %s", $realtime, results_seen, what);
		mismatch_total++;
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
		end
	endtask

	// CRC-6 over the address and data, MSB first, one bit at a time.
	function automatic logic [5:0] crc6_of_header(input logic [23:0] header);
		logic [5:0] crc;
		logic       feedback;
		crc = CRC6_SEED;
		for (int i = 23; i >= 0; i--) begin
			feedback = crc[5] ^ header[i];
			crc = {crc[4:0], 1'b0};
			if (feedback) begin
				crc ^= CRC6_TAPS;
			end
		end
		return crc;
	endfunction

	task automatic advance_frame_master(input logic [1:0] req_mode, input logic [7:0] req_addr,
			input logic [15:0] req_data, input logic req_sdo, output scfm_res_t res);
		logic [15:0] payload;
		res = '0;
		case (req_mode)
		MODE_WRITE, MODE_READ: begin
			if (in_transfer) begin
				res.rejected = 1'b1;
			end else begin
				payload     = (req_mode == MODE_READ) ? READ_DUMMY : req_data;
				tx_word     = {req_addr, payload, 2'b00, crc6_of_header({req_addr, payload})};
				rx_word     = '0;
				tick_count  = '0;
				in_transfer = 1'b1;
				read_txn    = (req_mode == MODE_READ);
			end
		end
		MODE_TICK: begin
			if (in_transfer) begin
				res.cs_active = 1'b1;
				if (tick_count < TX_TICKS) begin
					res.sdi = tx_word[31];
					tx_word = {tx_word[30:0], 1'b0};
					if (tick_count == TX_TICKS - 7'd1) begin
						res.frame_end = 1'b1;
						if (!read_txn) begin
							in_transfer = 1'b0;
						end
					end
				end else begin
					rx_word = {rx_word[30:0], req_sdo};
					if (tick_count >= ALL_TICKS - 7'd1) begin
						res.frame_end  = 1'b1;
						res.read_valid = 1'b1;
						res.read_data  = rx_word[23:8];
						in_transfer    = 1'b0;
					end
				end
				tick_count = in_transfer ? tick_count + 7'd1 : '0;
			end
		end
		default: begin
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_word        = '0;
			rx_word        = '0;
			tick_count     = '0;
			in_transfer    = 1'b0;
			read_txn       = 1'b0;
			mismatch_total = 0;
			results_seen   = 0;
			tick_results_q.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (tick_results_q.size() == 0) begin
					report_mismatch("result delivered with no request outstanding");
				end else begin
					expected = tick_results_q.pop_front();
					compare_field("cs_active", 16'(expected.cs_active), 16'(cs_active));
					compare_field("sdi", 16'(expected.sdi), 16'(sdi));
					compare_field("frame_end", 16'(expected.frame_end), 16'(frame_end));
					compare_field("read_valid", 16'(expected.read_valid), 16'(read_valid));
					compare_field("read_data", expected.read_data, read_data);
					compare_field("rejected", 16'(expected.rejected), 16'(rejected));
				end
				results_seen++;
			end
			if (in_valid && !in_stall) begin
				advance_frame_master(mode, address, write_data, sdo, predicted);
				tick_results_q.push_back(predicted);
			end
			mismatches <= mismatch_total;
			pending    <= tick_results_q.size();
		end
	end

endmodule

### tb/sv/spi_crc6_frame_master_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_crc6_frame_master_top_tb
// Drives write and read transactions, serial ticks and stray requests into the
// frame master under several idle and stall mixes, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module spi_crc6_frame_master_top_tb;
	import scfm_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int SDO_LOW      = 0;
	localparam int SDO_HIGH     = 1;
	localparam int SDO_RANDOM   = 2;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int PHASE_QUOTA  = 20;
	localparam int TAIL_CYCLES  = 4;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [1:0]  mode       = MODE_TICK;
	logic [7:0]  address    = '0;
	logic [15:0] write_data = '0;
	logic        sdo        = 1'b0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic        cs_active;
	logic        sdi;
	logic        frame_end;
	logic        read_valid;
	logic [15:0] read_data;
	logic        rejected;
	int          mismatches;
	int          pending;

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	logic        hold_armed     = 1'b0;
	logic        hold_seen      = 1'b0;
	int          hold_left      = 0;
	int          requests_sent  = 0;

	spi_crc6_frame_master_top u_dut (.*);

	spi_crc6_frame_master_checker u_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: random stalls, plus one long hold-off once it is armed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_seen) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_seen <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	task automatic send_request(input logic [1:0] req_mode, input logic [7:0] req_addr,
			input logic [15:0] req_data, input logic req_sdo);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= req_mode;
		address    <= req_addr;
		write_data <= req_data;
		sdo        <= req_sdo;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		requests_sent++;
	endtask

	// A stray request: the unused mode, or else a refused start while a frame runs and
	// an idle tick or the unused mode otherwise.
	task automatic send_noise(input bit frame_running);
		case ($urandom_range(0, 2))
		0: begin
			send_request(MODE_UNUSED, 8'($urandom), 16'($urandom), 1'($urandom));
		end
		1: begin
			send_request(frame_running ? MODE_WRITE : MODE_TICK, 8'($urandom),
				16'($urandom), 1'($urandom));
		end
		default: begin
			send_request(frame_running ? MODE_READ : MODE_UNUSED, 8'($urandom),
				16'($urandom), 1'($urandom));
		end
		endcase
	endtask

	task automatic tick_through(input int ticks, input int sdo_kind, input bit noisy);
		logic line;
		for (int i = 0; i < ticks; i++) begin
			if (noisy && $urandom_range(0, 99) < 8) begin
				send_noise(1'b1);
			end
			case (sdo_kind)
			SDO_LOW:  line = 1'b0;
			SDO_HIGH: line = 1'b1;
			default:  line = 1'($urandom);
			endcase
			send_request(MODE_TICK, 8'($urandom), 16'($urandom), line);
		end
	endtask

	task automatic random_traffic(input int quota);
		int first;
		int pick;
		first = requests_sent;
		while (requests_sent - first < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				send_noise(1'b0);
			end else if (pick < 56) begin
				send_request(MODE_WRITE, 8'($urandom), 16'($urandom), 1'($urandom));
				tick_through(FRAME_BITS, SDO_RANDOM, 1'b1);
			end else begin
				send_request(MODE_READ, 8'($urandom), 16'($urandom), 1'($urandom));
				tick_through(2 * FRAME_BITS, SDO_RANDOM, 1'b1);
			end
		end
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
	endtask

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle tick and unused mode before any frame exists.
		send_request(MODE_TICK, 8'hFF, 16'hFFFF, 1'b1);
		send_request(MODE_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
		// A write with every header bit set, then starts refused while it runs.
		send_request(MODE_WRITE, 8'hFF, 16'hFFFF, 1'b0);
		send_request(MODE_READ, 8'h00, 16'h0000, 1'b1);
		send_request(MODE_WRITE, 8'h5A, 16'h0000, 1'b0);
		send_request(MODE_UNUSED, 8'h00, 16'h0000, 1'b0);
		tick_through(FRAME_BITS, SDO_HIGH, 1'b0);
		send_request(MODE_TICK, 8'h00, 16'h0000, 1'b0);
		send_request(MODE_WRITE, 8'h00, 16'h0000, 1'b1);
		tick_through(FRAME_BITS, SDO_RANDOM, 1'b0);
		// Reads back to back: all ones on the device line, then all zeros.
		send_request(MODE_READ, 8'hFF, 16'hFFFF, 1'b1);
		tick_through(2 * FRAME_BITS, SDO_HIGH, 1'b0);
		send_request(MODE_READ, 8'h00, 16'h0000, 1'b0);
		tick_through(2 * FRAME_BITS, SDO_LOW, 1'b0);
		wait_for_drain();

		// No idling on either side, with one long hold-off on the result side.
		hold_armed <= 1'b1;
		random_traffic(PHASE_QUOTA);
		wait_for_drain();

		send_idle_pct = 78;
		random_traffic(PHASE_QUOTA);
		wait_for_drain();

		send_idle_pct = 0;
		recv_stall_pct <= 78;
		random_traffic(PHASE_QUOTA);
		wait_for_drain();

		send_idle_pct = 26;
		recv_stall_pct <= 26;
		random_traffic(PHASE_QUOTA);
		wait_for_drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/scfm_pkg.sv
hdl/scfm_front.sv
hdl/scfm_queue.sv
hdl/scfm_back.sv
hdl/spi_crc6_frame_master_top.sv
hdl/scfm_checker.sv
tb/sv/spi_crc6_frame_master_checker.sv
tb/sv/spi_crc6_frame_master_top_tb.sv
